[rtl/fpb_pkg.sv]
// Shared constants for the binary64 power-by-squaring block.
package fpb_pkg;
    localparam int EXP_WIDTH = 31;
    localparam int IDX_W     = $clog2(EXP_WIDTH);

    localparam logic [63:0] FP_ONE     = 64'h3FF0_0000_0000_0000;
    localparam logic [63:0] FP_DEF_NAN = 64'hFFF8_0000_0000_0000;

    typedef logic [63:0]          fp64_t;
    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [EXP_WIDTH-1:0] expo_t;
endpackage

[rtl/float_power_by_squaring.sv]
// Top level: binary64 base raised to an unsigned integer power by squaring.
// One item at a time. Squares base^(2^i) are formed from bit 0 up to the highest
// set exponent bit and kept in a small square store; the result is then built
// from that bit down, multiplying in each square whose exponent bit is set.
// All multiplies run on one shared multi-cycle binary64 multiplier, which forms
// partial products, normalizes, denormalizes, rounds and hands the result back.
// When an operand is subnormal, normalization shifts one bit per step until the
// leading bit is set or the exponent floor is reached. A square is launched and
// then awaited; a set product bit first reads its square from the store, and a
// clear bit only steps the index down.
// An item with highest set bit t and p set bits takes t squares and p products.
// An exponent of zero returns 1.0.
// in_stall is high from acceptance until the result item has been taken.
module float_power_by_squaring (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [63:0]            base_bits,
    input  logic [30:0]            exponent,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [63:0]            result_bits
);
    import fpb_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SQ_GO   = 3'd1;
    localparam logic [2:0] S_SQ_WAIT = 3'd2;
    localparam logic [2:0] S_LD      = 3'd3;
    localparam logic [2:0] S_LD_WAIT = 3'd4;
    localparam logic [2:0] S_MUL     = 3'd5;
    localparam logic [2:0] S_OUT     = 3'd6;

    logic [2:0] state_reg, state_next;
    expo_t      e_reg, e_next;      // exponent of the current item
    expo_t      rem_reg, rem_next;  // exponent bits above idx
    idx_t       idx_reg, idx_next;
    fp64_t      cur_reg, cur_next;  // latest square
    fp64_t      prod_reg, prod_next;

    // square store
    fp64_t sq_mem [EXP_WIDTH];
    fp64_t sq_rdata;
    logic  sq_we;
    idx_t  sq_waddr;
    fp64_t sq_wdata;

    logic  mul_start, mul_done;
    fp64_t mul_a, mul_b, mul_res;
    logic  accept;

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign in_stall = (state_reg != S_IDLE);

    fpb_fmul u_fmul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .res   (mul_res)
    );

    always_comb
    begin
        state_next = state_reg;
        e_next     = e_reg;
        rem_next   = rem_reg;
        idx_next   = idx_reg;
        cur_next   = cur_reg;
        prod_next  = prod_reg;
        sq_we      = 1'b0;
        sq_waddr   = idx_reg;
        sq_wdata   = mul_res;
        mul_start  = 1'b0;
        mul_a      = cur_reg;
        mul_b      = cur_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    e_next    = exponent;
                    rem_next  = exponent >> 1;
                    idx_next  = '0;
                    cur_next  = base_bits;
                    prod_next = FP_ONE;
                    sq_we     = 1'b1;
                    sq_waddr  = '0;
                    sq_wdata  = base_bits;
                    if (exponent == '0)
                        state_next = S_OUT;
                    else if ((exponent >> 1) != '0)
                        state_next = S_SQ_GO;
                    else
                        state_next = S_LD;
                end
            end
            S_SQ_GO:
            begin
                mul_start  = 1'b1;
                state_next = S_SQ_WAIT;
            end
            S_SQ_WAIT:
            begin
                if (mul_done)
                begin
                    cur_next = mul_res;
                    idx_next = idx_reg + idx_t'(1);
                    rem_next = rem_reg >> 1;
                    sq_we    = 1'b1;
                    sq_waddr = idx_reg + idx_t'(1);
                    // stop at the highest set bit
                    state_next = ((rem_reg >> 1) != '0) ? S_SQ_GO : S_LD;
                end
            end
            S_LD:
            begin
                if (e_reg[idx_reg])
                    state_next = S_LD_WAIT;
                else if (idx_reg == '0)
                    state_next = S_OUT;
                else
                    idx_next = idx_reg - idx_t'(1);
            end
            S_LD_WAIT:
            begin
                mul_a      = sq_rdata;
                mul_b      = prod_reg;
                mul_start  = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                if (mul_done)
                begin
                    prod_next = mul_res;
                    if (idx_reg == '0)
                        state_next = S_OUT;
                    else
                    begin
                        idx_next   = idx_reg - idx_t'(1);
                        state_next = S_LD;
                    end
                end
            end
            S_OUT:
            begin
                if (!out_stall)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (sq_we)
            sq_mem[sq_waddr] <= sq_wdata;
        sq_rdata <= sq_mem[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            prod_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            prod_reg  <= prod_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e_reg   <= e_next;
        rem_reg <= rem_next;
        idx_reg <= idx_next;
        cur_reg <= cur_next;
    end

    assign out_valid   = (state_reg == S_OUT);
    assign result_bits = prod_reg;
endmodule

[rtl/fpb_fmul.sv]
// Multi-cycle binary64 multiplier, round to nearest even.
module fpb_fmul (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  fpb_pkg::fp64_t a,
    input  fpb_pkg::fp64_t b,
    output logic          done,
    output fpb_pkg::fp64_t res
);
    import fpb_pkg::*;

    localparam logic [2:0] M_IDLE = 3'd0;
    localparam logic [2:0] M_PP   = 3'd1;
    localparam logic [2:0] M_NORM = 3'd2;
    localparam logic [2:0] M_DEN  = 3'd3;
    localparam logic [2:0] M_RND  = 3'd4;

    logic [2:0]   state_reg, state_next;
    logic         done_reg, done_next;
    fp64_t        res_reg, res_next;
    logic         sign_reg, sign_next;
    logic [52:0]  ma_reg, ma_next, mb_reg, mb_next;
    logic signed [13:0] r_reg, r_next;
    logic [105:0] acc_reg, acc_next;
    logic [53:0]  pp_reg, pp_next;
    logic [2:0]   k_reg, k_next;
    logic [1:0]   ksh_reg, ksh_next;

    // operand decode
    logic [10:0] ea, eb;
    logic [51:0] fa, fb;
    logic nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
    logic [26:0] opa, opb;
    logic [105:0] pp_ext;
    logic [13:0]  amt_full;
    logic [6:0]   amt;
    logic [211:0] dshift;
    logic [52:0]  mant;
    logic         grd, stk, up;
    logic [53:0]  mrnd;
    logic signed [13:0] rfin;
    logic [10:0]  efield;
    logic [51:0]  frac;

    always_comb
    begin
        ea = a[62:52];
        eb = b[62:52];
        fa = a[51:0];
        fb = b[51:0];
        nan_a  = (ea == 11'h7FF) && (fa != 52'd0);
        nan_b  = (eb == 11'h7FF) && (fb != 52'd0);
        inf_a  = (ea == 11'h7FF) && (fa == 52'd0);
        inf_b  = (eb == 11'h7FF) && (fb == 52'd0);
        zero_a = (ea == 11'd0) && (fa == 52'd0);
        zero_b = (eb == 11'd0) && (fb == 52'd0);

        opa = k_reg[0] ? {1'b0, ma_reg[52:27]} : ma_reg[26:0];
        opb = k_reg[1] ? {1'b0, mb_reg[52:27]} : mb_reg[26:0];

        case (ksh_reg)
            2'd0:    pp_ext = {52'd0, pp_reg};
            2'd3:    pp_ext = {52'd0, pp_reg} << 54;
            default: pp_ext = {52'd0, pp_reg} << 27;
        endcase

        // right shift into the subnormal range, lost bits fold into sticky
        amt_full = 14'sd1 - r_reg;
        amt      = (amt_full > 14'sd127) ? 7'd127 : amt_full[6:0];
        dshift   = {acc_reg, 106'd0} >> amt;

        mant = acc_reg[105:53];
        grd  = acc_reg[52];
        stk  = |acc_reg[51:0];
        up   = grd & (stk | mant[0]);
        mrnd = {1'b0, mant} + {53'd0, up};
        if (mrnd[53])
        begin
            rfin = r_reg + 14'sd1;
            frac = 52'd0;
        end
        else
        begin
            rfin = r_reg;
            frac = mrnd[51:0];
        end
        efield = (mrnd[53] || mrnd[52]) ? rfin[10:0] : 11'd0;
    end

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        sign_next  = sign_reg;
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        r_next     = r_reg;
        acc_next   = acc_reg;
        pp_next    = pp_reg;
        k_next     = k_reg;
        ksh_next   = ksh_reg;
        case (state_reg)
            M_IDLE:
            begin
                if (start)
                begin
                    if (nan_a)
                    begin
                        res_next  = a | 64'h0008_0000_0000_0000;
                        done_next = 1'b1;
                    end
                    else if (nan_b)
                    begin
                        res_next  = b | 64'h0008_0000_0000_0000;
                        done_next = 1'b1;
                    end
                    else if (inf_a || inf_b)
                    begin
                        res_next  = (zero_a || zero_b) ? FP_DEF_NAN
                                  : {a[63] ^ b[63], 11'h7FF, 52'd0};
                        done_next = 1'b1;
                    end
                    else if (zero_a || zero_b)
                    begin
                        res_next  = {a[63] ^ b[63], 63'd0};
                        done_next = 1'b1;
                    end
                    else
                    begin
                        sign_next  = a[63] ^ b[63];
                        ma_next    = {ea != 11'd0, fa};
                        mb_next    = {eb != 11'd0, fb};
                        r_next     = $signed({3'b0, (ea == 11'd0) ? 11'd1 : ea})
                                   + $signed({3'b0, (eb == 11'd0) ? 11'd1 : eb})
                                   - 14'sd1022;
                        acc_next   = 106'd0;
                        k_next     = 3'd0;
                        state_next = M_PP;
                    end
                end
            end
            M_PP:
            begin
                // one 27x27 partial product per cycle, added the cycle after
                if (k_reg != 3'd4)
                begin
                    pp_next  = opa * opb;
                    ksh_next = k_reg[1:0];
                end
                if (k_reg != 3'd0)
                    acc_next = acc_reg + pp_ext;
                k_next = k_reg + 3'd1;
                if (k_reg == 3'd4)
                    state_next = M_NORM;
            end
            M_NORM:
            begin
                if (!acc_reg[105] && (r_reg > 14'sd1))
                begin
                    acc_next = acc_reg << 1;
                    r_next   = r_reg - 14'sd1;
                end
                else
                    state_next = M_DEN;
            end
            M_DEN:
            begin
                if (r_reg < 14'sd1)
                begin
                    acc_next = dshift[211:106] | {105'd0, |dshift[105:0]};
                    r_next   = 14'sd1;
                end
                state_next = M_RND;
            end
            M_RND:
            begin
                if (rfin >= 14'sd2047)
                    res_next = {sign_reg, 11'h7FF, 52'd0};
                else
                    res_next = {sign_reg, efield, frac};
                done_next  = 1'b1;
                state_next = M_IDLE;
            end
            default: state_next = M_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            done_reg  <= 1'b0;
            k_reg     <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg  <= res_next;
        sign_reg <= sign_next;
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        r_reg    <= r_next;
        acc_reg  <= acc_next;
        pp_reg   <= pp_next;
        ksh_reg  <= ksh_next;
    end

    assign done = done_reg;
    assign res  = res_reg;
endmodule

[dv/tb.sv]
// Testbench for float_power_by_squaring: directed and random powers checked against a predictor.
`timescale 1ns / 1ps

module tb;
    import fpb_pkg::*;

    // Driver feeds from pending_items. Each accepted item pushes its predicted
    // power into expected_powers. The monitor checks results in order.
    // The predictor uses the simulator's real type, which is an IEEE binary64
    // with round-to-nearest-even, so each step rounds the same way as the block.

    typedef struct packed {
        fp64_t base;
        expo_t expo;
    } power_item_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [63:0] base_bits;
    logic [30:0] exponent;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] result_bits;

    power_item_t pending_items[$];
    fp64_t       expected_powers[$];
    int          error_count;
    int          checked_count;
    int          cycle_count;
    bit          in_taken;

    float_power_by_squaring uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .base_bits  (base_bits),
        .exponent   (exponent),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .result_bits(result_bits)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Power by squaring with every multiply rounded to binary64.
    // Squares go up to the highest set bit. The product is then built from
    // that bit down to bit 0.
    function automatic fp64_t power_predict(fp64_t base, expo_t expo);
        real squares[EXP_WIDTH];
        real acc;
        int  top;
        top = -1;
        acc = 1.0;
        for (int i = 0; i < EXP_WIDTH; i++)
        begin
            if (expo[i])
                top = i;
        end
        if (top >= 0)
        begin
            squares[0] = $bitstoreal(base);
            for (int i = 1; i <= top; i++)
                squares[i] = squares[i-1] * squares[i-1];
            for (int i = top; i >= 0; i--)
            begin
                if (expo[i])
                    acc = squares[i] * acc;
            end
        end
        return $realtobits(acc);
    endfunction

    // Idle with a chance of 35 in 100 on each call, except inside one quiet window.
    function automatic bit idle_now();
        if (cycle_count >= 30000 && cycle_count < 80000)
            return 1'b0;
        return $urandom_range(99) < 35;
    endfunction

    task automatic add_item(fp64_t b, expo_t e);
        power_item_t it;
        it.base = b;
        it.expo = e;
        pending_items.push_back(it);
    endtask

    // Sampled at the rising edge. An item moves when valid is high and stall is low.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        in_taken    <= in_valid && !in_stall;
        if (in_valid && !in_stall)
            expected_powers.push_back(power_predict(base_bits, exponent));
        if (out_valid && !out_stall)
        begin
            if (expected_powers.size() == 0)
            begin
                $display("%0t: result with nothing expected: expected none, actual %h",
                         $time, result_bits);
                error_count <= error_count + 1;
            end
            else
            begin
                if (result_bits !== expected_powers[0])
                begin
                    $display("%0t: result_bits mismatch: expected %h, actual %h",
                             $time, expected_powers[0], result_bits);
                    error_count <= error_count + 1;
                end
                void'(expected_powers.pop_front());
                checked_count <= checked_count + 1;
            end
        end
    end

    // Inputs change at the falling edge. The payload is held until it is taken.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            out_stall <= 1'b0;
        end
        else
        begin
            out_stall <= idle_now();
            if (!in_valid || in_taken)
            begin
                if (pending_items.size() != 0 && !idle_now())
                begin
                    base_bits <= pending_items[0].base;
                    exponent  <= pending_items[0].expo;
                    in_valid  <= 1'b1;
                    void'(pending_items.pop_front());
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    initial
    begin
        fp64_t b;
        expo_t e;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        out_stall     = 1'b0;
        base_bits     = '0;
        exponent      = '0;
        error_count   = 0;
        checked_count = 0;
        cycle_count   = 0;
        in_taken      = 1'b0;

        // A zero exponent gives exactly 1.0, even for a NaN or an infinite base.
        add_item(64'h7FF8_0000_0000_0001, '0);
        add_item(64'h7FF0_0000_0000_0000, '0);
        add_item(64'h0000_0000_0000_0000, '0);
        add_item(64'h4000_0000_0000_0000, 31'd1);
        add_item(64'hFFFF_FFFF_FFFF_FFFF, 31'd1);
        add_item(64'hBFF0_0000_0000_0000, 31'h7FFF_FFFF);
        add_item(64'h3FF0_0000_0000_0001, 31'h7FFF_FFFF);
        add_item(64'h8000_0000_0000_0000, 31'd3);
        add_item(64'hFFF0_0000_0000_0000, 31'd5);
        add_item(64'h7FF4_0000_0000_0000, 31'd6);
        add_item(64'h0000_0000_0000_0001, 31'd1);
        add_item(64'h0000_0000_0000_0001, 31'd2);
        add_item(64'h000F_FFFF_FFFF_FFFF, 31'd3);
        add_item(64'h4000_0000_0000_0000, 31'd1023);
        add_item(64'h4000_0000_0000_0000, 31'd1024);
        add_item(64'h3FE0_0000_0000_0000, 31'd1074);
        add_item(64'h3FE0_0000_0000_0000, 31'd1075);
        add_item(64'h3FE0_0000_0000_0000, 31'd1022);
        add_item(64'h7FEF_FFFF_FFFF_FFFF, 31'd2);
        add_item(64'hC008_0000_0000_0000, 31'd7);
        add_item(64'h3FF0_0000_0000_0000, 31'h4000_0000);

        // Random part. One case in four puts the base near magnitude 1. The rest
        // use any bit pattern, two cases in three of those with a shortened exponent.
        for (int n = 0; n < 400; n++)
        begin
            b = {$urandom, $urandom};
            e = expo_t'($urandom);
            case ($urandom_range(3))
                0: b[62:52] = 11'h3FF - 11'($urandom_range(1));
                1: e = e >> $urandom_range(30);
                2: e = e >> $urandom_range(30, 20);
                default: ;
            endcase
            add_item(b, e);
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (pending_items.size() == 0 && !in_valid);
        wait (expected_powers.size() == 0);
        repeat (600) @(posedge clk);

        $display("Covered %0d results: zero and full 31-bit exponents, NaN/inf/zero bases,",
                 checked_count);
        $display("subnormal, overflow and underflow powers, with random stalls on both sides.");
        if (error_count == 0 && expected_powers.size() == 0)
            $display("float_power_by_squaring verification clean");
        else
            $display("float_power_by_squaring verification failed");
        $finish;
    end

    // Generous fixed bound on the whole run.
    initial
    begin
        #40_000_000;
        $display("float_power_by_squaring verification failed");
        $finish;
    end
endmodule
